// ===== hw/rtl/dpwp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpwp_pkg
// Widths, register indexes and word types shared by the depth pixel to
// world point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dpwp_pkg;

  // default number of raw depth bits taken from the sample
  localparam int DEPTH_BITS_DEF = 16;

  // field widths
  localparam int RAW_PORT_W = 16;
  localparam int RAY_W      = 20;
  localparam int OUT_W      = 24;
  localparam int SCALE_W    = 32;
  localparam int COEF_W     = 18;
  localparam int TRANS_W    = 20;
  localparam int LIM_W      = 24;
  localparam int ROT_W      = 3 * COEF_W;
  localparam int TRANSV_W   = 3 * TRANS_W;

  // internal datapath widths
  localparam int DEPTH_W = 24;   // kept depth, below the far limit
  localparam int CAM_W   = 28;   // camera x and y, Q.16 signed
  localparam int WORLD_W = 32;   // unsaturated world coordinate, Q.16 signed

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_SCALE  = 3'd0,
    REG_ROT_ROW_X    = 3'd1,
    REG_ROT_ROW_Y    = 3'd2,
    REG_ROT_ROW_Z    = 3'd3,
    REG_TRANSLATION  = 3'd4,
    REG_DEPTH_LIMITS = 3'd5,
    REG_HEIGHT_LIMIT = 3'd6
  } cfg_reg_t;

  // configuration as seen by the pipeline
  typedef struct packed {
    logic [SCALE_W-1:0]  depth_scale;
    logic [ROT_W-1:0]    rot_row_x;
    logic [ROT_W-1:0]    rot_row_y;
    logic [ROT_W-1:0]    rot_row_z;
    logic [TRANSV_W-1:0] translation;
    logic [LIM_W-1:0]    near_limit;
    logic [LIM_W-1:0]    far_limit;
    logic [LIM_W-1:0]    height_limit;
  } cfg_t;

  // scaled and range-checked depth with its ray
  typedef struct packed {
    logic [DEPTH_W-1:0]      depth;
    logic signed [RAY_W-1:0] ray_x;
    logic signed [RAY_W-1:0] ray_y;
  } depth_word_t;

  // camera space point
  typedef struct packed {
    logic signed [CAM_W-1:0] xc;
    logic signed [CAM_W-1:0] yc;
    logic [DEPTH_W-1:0]      zc;
  } cam_word_t;

  // world space point before the height check
  typedef struct packed {
    logic signed [WORLD_W-1:0] wx;
    logic signed [WORLD_W-1:0] wy;
    logic signed [WORLD_W-1:0] wz;
  } world_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dpwp_if.sv =====
// ----------------------------------------------------------------------------
// dpwp_if
// Valid/ready channels for depth pixel words and world point words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpwp_pix_if;
  import dpwp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [RAW_PORT_W-1:0]   depth_raw;
  logic signed [RAY_W-1:0] ray_x;
  logic signed [RAY_W-1:0] ray_y;

  modport source (output valid, depth_raw, ray_x, ray_y, input ready);
  modport sink   (input valid, depth_raw, ray_x, ray_y, output ready);
endinterface

interface dpwp_pnt_if;
  import dpwp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;
  logic signed [OUT_W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dpwp_scale.sv =====
// ----------------------------------------------------------------------------
// dpwp_scale
// Two stages: raw depth times scale factor, then the near/far range gate.
// Pixels outside the range leave the pipeline here.
// ----------------------------------------------------------------------------
`default_nettype none

module dpwp_scale #(
  parameter int DEPTH_BITS = dpwp_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dpwp_pkg::cfg_t                    cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [dpwp_pkg::RAW_PORT_W-1:0]   in_depth_raw,
  input  wire logic signed [dpwp_pkg::RAY_W-1:0] in_ray_x,
  input  wire logic signed [dpwp_pkg::RAY_W-1:0] in_ray_y,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output dpwp_pkg::depth_word_t                  out_word
);
  import dpwp_pkg::*;

  // bits of the sample that take part, never more than the port carries
  localparam int RAW_W   = (DEPTH_BITS < RAW_PORT_W) ? DEPTH_BITS : RAW_PORT_W;
  localparam int PROD_W  = RAW_W + SCALE_W;
  localparam int DFULL_W = PROD_W - 16;

  logic                    v1_r;
  logic [DFULL_W-1:0]      dfull_r;
  logic signed [RAY_W-1:0] rx1_r;
  logic signed [RAY_W-1:0] ry1_r;
  logic                    v2_r;
  depth_word_t             word2_r;

  logic               en1;
  logic               en2;
  logic [PROD_W-1:0]  prod;
  logic [DFULL_W-1:0] near_ext;
  logic [DFULL_W-1:0] far_ext;
  logic               keep;

  // stage enables, a stage moves when empty or when its successor moves
  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // scale raw depth to Q.16 metres
  assign prod = PROD_W'(in_depth_raw[RAW_W-1:0]) * PROD_W'(cfg.depth_scale);

  // strict near/far window
  assign near_ext = DFULL_W'(cfg.near_limit);
  assign far_ext  = DFULL_W'(cfg.far_limit);
  assign keep     = (dfull_r > near_ext) && (dfull_r < far_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r && keep;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) begin
      dfull_r <= prod[PROD_W-1:16];
      rx1_r   <= in_ray_x;
      ry1_r   <= in_ray_y;
    end
    if (en2) begin
      word2_r.depth <= dfull_r[DEPTH_W-1:0];
      word2_r.ray_x <= rx1_r;
      word2_r.ray_y <= ry1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_word  = word2_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dpwp_backproj.sv =====
// ----------------------------------------------------------------------------
// dpwp_backproj
// Back-projects a kept depth along its ray to a camera space point.
// ----------------------------------------------------------------------------
`default_nettype none

module dpwp_backproj (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dpwp_pkg::depth_word_t in_word,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dpwp_pkg::cam_word_t        out_word
);
  import dpwp_pkg::*;

  localparam int PROD_W = RAY_W + DEPTH_W + 1;

  logic        v_r;
  cam_word_t   word_r;
  logic        en;

  logic signed [DEPTH_W:0]  depth_s;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] px_sh;
  logic signed [PROD_W-1:0] py_sh;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  // ray times depth, floor of the Q.16 result by arithmetic shift
  assign depth_s = $signed({1'b0, in_word.depth});
  assign px      = PROD_W'(in_word.ray_x) * PROD_W'(depth_s);
  assign py      = PROD_W'(in_word.ray_y) * PROD_W'(depth_s);
  assign px_sh   = px >>> 16;
  assign py_sh   = py >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r.xc <= px_sh[CAM_W-1:0];
      word_r.yc <= py_sh[CAM_W-1:0];
      word_r.zc <= in_word.depth;
    end
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dpwp_pose.sv =====
// ----------------------------------------------------------------------------
// dpwp_pose
// Camera to world transform: nine coefficient products in one stage,
// row sums with translation and the Q.16 floor in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module dpwp_pose (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dpwp_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dpwp_pkg::cam_word_t in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dpwp_pkg::world_word_t    out_word
);
  import dpwp_pkg::*;

  localparam int PROD_W = COEF_W + CAM_W;
  localparam int ACC_W  = 48;

  logic                     v1_r;
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic                     v2_r;
  world_word_t              word2_r;

  logic                     en1;
  logic                     en2;
  logic signed [COEF_W-1:0] coef   [3][3];
  logic signed [CAM_W-1:0]  cam_op [3];
  logic signed [ACC_W-1:0]  acc    [3];
  logic signed [ACC_W-1:0]  acc_sh [3];
  logic [ROT_W-1:0]         rows   [3];

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // unpack rotation rows and camera operands
  always_comb begin
    rows[0]   = cfg.rot_row_x;
    rows[1]   = cfg.rot_row_y;
    rows[2]   = cfg.rot_row_z;
    cam_op[0] = in_word.xc;
    cam_op[1] = in_word.yc;
    cam_op[2] = $signed(CAM_W'(in_word.zc));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = $signed(rows[i][j*COEF_W +: COEF_W]);
      end
    end
  end

  // row sums plus translation scaled from Q.14 to Q.32
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = {{(ACC_W-PROD_W){prod_r[i][0][PROD_W-1]}}, prod_r[i][0]}
             + {{(ACC_W-PROD_W){prod_r[i][1][PROD_W-1]}}, prod_r[i][1]}
             + {{(ACC_W-PROD_W){prod_r[i][2][PROD_W-1]}}, prod_r[i][2]}
             + ($signed(ACC_W'($signed(cfg.translation[i*TRANS_W +: TRANS_W]))) <<< 18);
      acc_sh[i] = acc[i] >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= PROD_W'(coef[i][j]) * PROD_W'(cam_op[j]);
        end
      end
    end
  end

  // world coordinates
  always_ff @(posedge clk) begin
    if (en2) begin
      word2_r.wx <= acc_sh[0][WORLD_W-1:0];
      word2_r.wy <= acc_sh[1][WORLD_W-1:0];
      word2_r.wz <= acc_sh[2][WORLD_W-1:0];
    end
  end

  assign out_valid = v2_r;
  assign out_word  = word2_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dpwp_emit.sv =====
// ----------------------------------------------------------------------------
// dpwp_emit
// Height gate and output saturation; holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpwp_emit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dpwp_pkg::cfg_t         cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire dpwp_pkg::world_word_t  in_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [dpwp_pkg::OUT_W-1:0] out_point_x,
  output logic signed [dpwp_pkg::OUT_W-1:0] out_point_y,
  output logic signed [dpwp_pkg::OUT_W-1:0] out_point_z
);
  import dpwp_pkg::*;

  localparam logic signed [WORLD_W-1:0] SAT_MAX = WORLD_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [WORLD_W-1:0] SAT_MIN = -WORLD_W'(2 ** (OUT_W - 1));

  // clamp to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WORLD_W-1:0] v);
    logic signed [WORLD_W-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return c[OUT_W-1:0];
  endfunction

  logic                    v_r;
  logic signed [OUT_W-1:0] px_r;
  logic signed [OUT_W-1:0] py_r;
  logic signed [OUT_W-1:0] pz_r;

  logic               en;
  logic [WORLD_W-1:0] abs_y;
  logic               height_ok;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  // absolute height against the limit, on the unsaturated value
  assign abs_y     = in_word.wy[WORLD_W-1] ? (~in_word.wy + 1'b1) : in_word.wy;
  assign height_ok = abs_y < WORLD_W'(cfg.height_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid && height_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= sat_out(in_word.wx);
      py_r <= sat_out(in_word.wy);
      pz_r <= sat_out(in_word.wz);
    end
  end

  assign out_valid   = v_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;
  assign out_point_z = pz_r;

endmodule

`default_nettype wire

// ===== hw/rtl/depth_pixel_to_world_point_core.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_core
// Depth pixel to world point pipeline: scale, range gate, back-projection,
// pose transform, height gate and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix carries one depth pixel word (raw depth, ray x, ray y) per
//   valid/ready handshake; out_pnt carries one world point word (x, y, z).
//   Pixels not strictly inside the near/far window or with |y| >= the height
//   limit give no word on out_pnt; all others give one each, in arrival order.
//   The cfg_ port writes one register per cycle with cfg_we high; write it
//   only while the pipeline is empty.
//   Six register stages: two in the depth scale and range stages, one in
//   back-projection, two in the pose multiply and sum stages, one in the
//   output register. Throughput is one pixel per cycle while out_pnt.ready
//   stays high, set by the fully pipelined multiplier stages; each stage
//   advances when it is empty or when the stage after it advances.
//   When out_pnt.ready is low the words held in the stages stay put and
//   empty stages keep filling, so bubbles close up before in_pix.ready drops.
//   Synchronous reset clears all valid bits and zeroes the cfg registers,
//   so after reset every pixel is rejected until the far limit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_to_world_point_core #(
  parameter int DEPTH_BITS = dpwp_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dpwp_pix_if.sink                               in_pix,
  dpwp_pnt_if.source                             out_pnt,
  input  wire logic                              cfg_we,
  input  wire logic [dpwp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [dpwp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dpwp_pkg::*;

  cfg_t cfg_r;

  logic        sc_valid;
  logic        sc_ready;
  depth_word_t sc_word;
  logic        bp_valid;
  logic        bp_ready;
  cam_word_t   bp_word;
  logic        ps_valid;
  logic        ps_ready;
  world_word_t ps_word;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_DEPTH_SCALE:  cfg_r.depth_scale  <= cfg_data[SCALE_W-1:0];
        REG_ROT_ROW_X:    cfg_r.rot_row_x    <= cfg_data[ROT_W-1:0];
        REG_ROT_ROW_Y:    cfg_r.rot_row_y    <= cfg_data[ROT_W-1:0];
        REG_ROT_ROW_Z:    cfg_r.rot_row_z    <= cfg_data[ROT_W-1:0];
        REG_TRANSLATION:  cfg_r.translation  <= cfg_data[TRANSV_W-1:0];
        REG_DEPTH_LIMITS: begin
          cfg_r.near_limit <= cfg_data[LIM_W-1:0];
          cfg_r.far_limit  <= cfg_data[2*LIM_W-1:LIM_W];
        end
        REG_HEIGHT_LIMIT: cfg_r.height_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // depth scale and range gate
  dpwp_scale #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_pix.valid),
    .in_ready     (in_pix.ready),
    .in_depth_raw (in_pix.depth_raw),
    .in_ray_x     (in_pix.ray_x),
    .in_ray_y     (in_pix.ray_y),
    .out_valid    (sc_valid),
    .out_ready    (sc_ready),
    .out_word     (sc_word)
  );

  // camera point
  dpwp_backproj u_backproj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_word   (sc_word),
    .out_valid (bp_valid),
    .out_ready (bp_ready),
    .out_word  (bp_word)
  );

  // world point
  dpwp_pose u_pose (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (bp_valid),
    .in_ready  (bp_ready),
    .in_word   (bp_word),
    .out_valid (ps_valid),
    .out_ready (ps_ready),
    .out_word  (ps_word)
  );

  // height gate and output register
  dpwp_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (ps_valid),
    .in_ready    (ps_ready),
    .in_word     (ps_word),
    .out_valid   (out_pnt.valid),
    .out_ready   (out_pnt.ready),
    .out_point_x (out_pnt.point_x),
    .out_point_y (out_pnt.point_y),
    .out_point_z (out_pnt.point_z)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth pixel to world point core. Depth pixel
// words go in through a bursty sender while the point side stalls on its own
// pattern. Every accepted pixel is run through a local fixed-point model of
// the scale, range gate, back-projection, pose transform, height gate and
// saturation. Each point word that comes out is compared with the oldest
// prediction. Directed edge cases come first, then random pixels under
// several pose settings.
// ----------------------------------------------------------------------------

module tb_top;
  import dpwp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int PIPE_LATENCY = 6;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 150;
  localparam int DEPTH_BITS   = DEPTH_BITS_DEF;

  // index outside the register map
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // fixed-point reference values
  localparam logic [SCALE_W-1:0]      SCALE_X16  = 32'h0010_0000;  // depth = raw * 16
  localparam logic [LIM_W-1:0]        NEAR_TYP   = 24'd6554;       // 0.1 m
  localparam logic [LIM_W-1:0]        NEAR_EDGE  = 24'd6560;       // raw 410 at x16
  localparam logic [LIM_W-1:0]        FAR_TYP    = 24'd786432;     // 12.0 m
  localparam logic [LIM_W-1:0]        HEIGHT_TYP = 24'd36045;      // 0.55 m
  localparam logic signed [RAY_W-1:0] RAY_HEIGHT = 20'sd36045;
  localparam logic signed [RAY_W-1:0] RAY_MAX    = 20'sh7FFFF;
  localparam logic signed [RAY_W-1:0] RAY_MIN    = 20'sh80000;
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = 18'sh1FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = 18'sh20000;
  localparam logic signed [TRANS_W-1:0] TRANS_MAX = 20'sh7FFFF;
  localparam logic signed [TRANS_W-1:0] TRANS_MIN = 20'sh80000;
  localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (OUT_W - 1));

  typedef enum int {
    POSE_LEVEL,
    POSE_RANDOM,
    POSE_SWAPPED,
    POSE_FULL_SCALE,
    POSE_FINE_SCALE
  } pose_kind_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } point_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dpwp_pix_if pix_if ();
  dpwp_pnt_if pnt_if ();

  depth_pixel_to_world_point_core #(.DEPTH_BITS(DEPTH_BITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_pnt (pnt_if),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // shadow of the pose registers and the points still to come
  cfg_t   pose_cfg;
  point_t expected_points[$];

  int burst_left     = 0;
  bit steady_stream  = 1'b0;
  int pixels_sent    = 0;
  int points_checked = 0;
  int err_count      = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;

  logic [15:0] stall_pattern = 16'hFFFF;
  int          pattern_age   = 0;

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed-point model of the pipeline
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] scaled_depth(input cfg_t c,
                                               input logic [RAW_PORT_W-1:0] raw);
    logic [63:0] used;
    used = 64'(raw) & ((64'd1 << DEPTH_BITS) - 64'd1);
    return (used * 64'(c.depth_scale)) >> 16;
  endfunction

  // one row of the pose: rotation dot camera point plus translation, floored
  function automatic longint pose_row(input logic [ROT_W-1:0] row,
                                      input logic [TRANS_W-1:0] t,
                                      input longint xc, input longint yc,
                                      input longint zc);
    longint acc;
    acc = longint'($signed(row[COEF_W-1:0])) * xc
        + longint'($signed(row[2*COEF_W-1:COEF_W])) * yc
        + longint'($signed(row[3*COEF_W-1:2*COEF_W])) * zc
        + (longint'($signed(t)) <<< 18);
    return acc >>> 16;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    if (v > OUT_MAX) return OUT_W'(OUT_MAX);
    if (v < OUT_MIN) return OUT_W'(OUT_MIN);
    return OUT_W'(v);
  endfunction

  function automatic bit project_pixel(input cfg_t c,
                                       input logic [RAW_PORT_W-1:0] raw,
                                       input logic signed [RAY_W-1:0] rx,
                                       input logic signed [RAY_W-1:0] ry,
                                       output point_t p);
    logic [63:0] d_full;
    longint      d, xc, yc, wx, wy, wz, ay;
    p = '{default: '0};
    d_full = scaled_depth(c, raw);
    // range gate, strict on both sides
    if (!(d_full > 64'(c.near_limit) && d_full < 64'(c.far_limit))) return 1'b0;
    d  = longint'(d_full);
    xc = (longint'(rx) * d) >>> 16;
    yc = (longint'(ry) * d) >>> 16;
    wx = pose_row(c.rot_row_x, c.translation[TRANS_W-1:0], xc, yc, d);
    wy = pose_row(c.rot_row_y, c.translation[2*TRANS_W-1:TRANS_W], xc, yc, d);
    wz = pose_row(c.rot_row_z, c.translation[3*TRANS_W-1:2*TRANS_W], xc, yc, d);
    // height gate on the unsaturated y
    ay = (wy < 0) ? -wy : wy;
    if (!(ay < longint'(c.height_limit))) return 1'b0;
    p.x = clamp_out(wx);
    p.y = clamp_out(wy);
    p.z = clamp_out(wz);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // pose building
  // ---------------------------------------------------------------------------

  function automatic logic [ROT_W-1:0] pack_row(input logic signed [COEF_W-1:0] c0,
                                                input logic signed [COEF_W-1:0] c1,
                                                input logic signed [COEF_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [TRANSV_W-1:0] pack_trans(input logic signed [TRANS_W-1:0] tx,
                                                     input logic signed [TRANS_W-1:0] ty,
                                                     input logic signed [TRANS_W-1:0] tz);
    return {tz, ty, tx};
  endfunction

  // small coefficient offset, about +-0.03
  function automatic logic signed [COEF_W-1:0] small_coef();
    return COEF_W'($urandom_range(0, 4096)) - 18'sd2048;
  endfunction

  // translation within about +-1 m
  function automatic logic signed [TRANS_W-1:0] small_trans();
    return TRANS_W'($urandom_range(0, 32768)) - 20'sd16384;
  endfunction

  function automatic cfg_t typical_pose();
    cfg_t c;
    c.depth_scale  = SCALE_X16;
    c.rot_row_x    = pack_row(COEF_ONE, 0, 0);
    c.rot_row_y    = pack_row(0, COEF_ONE, 0);
    c.rot_row_z    = pack_row(0, 0, COEF_ONE);
    c.translation  = '0;
    c.near_limit   = NEAR_TYP;
    c.far_limit    = FAR_TYP;
    c.height_limit = HEIGHT_TYP;
    return c;
  endfunction

  function automatic cfg_t random_pose(input pose_kind_t kind);
    cfg_t             c;
    logic [LIM_W-1:0] lim_a, lim_b;
    c = typical_pose();
    case (kind)
      POSE_LEVEL: begin
        c.rot_row_x   = pack_row(COEF_ONE + small_coef(), small_coef(), small_coef());
        c.rot_row_y   = pack_row(small_coef(), COEF_ONE + small_coef(), small_coef());
        c.rot_row_z   = pack_row(small_coef(), small_coef(), COEF_ONE + small_coef());
        c.translation = pack_trans(small_trans(), small_trans(), small_trans());
      end
      POSE_RANDOM: begin
        lim_a          = LIM_W'($urandom);
        lim_b          = LIM_W'($urandom);
        c.depth_scale  = $urandom;
        c.rot_row_x    = ROT_W'({$urandom, $urandom});
        c.rot_row_y    = ROT_W'({$urandom, $urandom});
        c.rot_row_z    = ROT_W'({$urandom, $urandom});
        c.translation  = TRANSV_W'({$urandom, $urandom});
        c.near_limit   = (lim_a < lim_b) ? lim_a : lim_b;
        c.far_limit    = (lim_a < lim_b) ? lim_b : lim_a;
        c.height_limit = LIM_W'($urandom);
      end
      POSE_SWAPPED: begin
        // camera forward becomes world x, camera y flipped
        c.depth_scale  = $urandom_range(32'h0004_0000, 32'h0040_0000);
        c.rot_row_x    = pack_row(small_coef(), small_coef(), COEF_ONE + small_coef());
        c.rot_row_y    = pack_row(small_coef(), -COEF_ONE + small_coef(), small_coef());
        c.rot_row_z    = pack_row(COEF_ONE + small_coef(), small_coef(), small_coef());
        c.translation  = pack_trans(small_trans(), small_trans(), small_trans());
        c.height_limit = '1;
      end
      POSE_FULL_SCALE: begin
        c.depth_scale  = '1;
        c.rot_row_x    = ROT_W'({$urandom, $urandom});
        c.rot_row_y    = ROT_W'({$urandom, $urandom});
        c.rot_row_z    = ROT_W'({$urandom, $urandom});
        c.translation  = TRANSV_W'({$urandom, $urandom});
        c.near_limit   = '0;
        c.far_limit    = '1;
        c.height_limit = '1;
      end
      POSE_FINE_SCALE: begin
        c.depth_scale  = $urandom_range(16, 4096);
        c.rot_row_x    = ROT_W'({$urandom, $urandom});
        c.rot_row_y    = ROT_W'({$urandom, $urandom});
        c.rot_row_z    = ROT_W'({$urandom, $urandom});
        c.translation  = TRANSV_W'({$urandom, $urandom});
        c.near_limit   = '0;
        c.far_limit    = LIM_W'($urandom_range(1, 4096));
        c.height_limit = '1;
      end
      default: ;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // register writes
  // ---------------------------------------------------------------------------

  // random bits above the register width, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] field,
                                                       input int width);
    logic [63:0] mask;
    logic [63:0] junk;
    mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    junk = {$urandom, $urandom};
    return CFG_DATA_W'((junk & ~mask) | (64'(field) & mask));
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_DEPTH_SCALE:  pose_cfg.depth_scale = data[SCALE_W-1:0];
      REG_ROT_ROW_X:    pose_cfg.rot_row_x   = data[ROT_W-1:0];
      REG_ROT_ROW_Y:    pose_cfg.rot_row_y   = data[ROT_W-1:0];
      REG_ROT_ROW_Z:    pose_cfg.rot_row_z   = data[ROT_W-1:0];
      REG_TRANSLATION:  pose_cfg.translation = data[TRANSV_W-1:0];
      REG_DEPTH_LIMITS: begin
        pose_cfg.near_limit = data[LIM_W-1:0];
        pose_cfg.far_limit  = data[2*LIM_W-1:LIM_W];
      end
      REG_HEIGHT_LIMIT: pose_cfg.height_limit = data[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_pose(input cfg_t c);
    cfg_write(REG_DEPTH_SCALE,  with_junk(CFG_DATA_W'(c.depth_scale), SCALE_W));
    cfg_write(REG_ROT_ROW_X,    with_junk(CFG_DATA_W'(c.rot_row_x), ROT_W));
    cfg_write(REG_ROT_ROW_Y,    with_junk(CFG_DATA_W'(c.rot_row_y), ROT_W));
    cfg_write(REG_ROT_ROW_Z,    with_junk(CFG_DATA_W'(c.rot_row_z), ROT_W));
    cfg_write(REG_TRANSLATION,  with_junk(CFG_DATA_W'(c.translation), TRANSV_W));
    cfg_write(REG_DEPTH_LIMITS,
              with_junk(CFG_DATA_W'({c.far_limit, c.near_limit}), 2 * LIM_W));
    cfg_write(REG_HEIGHT_LIMIT, with_junk(CFG_DATA_W'(c.height_limit), LIM_W));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // pixel sender
  // ---------------------------------------------------------------------------

  task automatic send_pixel(input logic [RAW_PORT_W-1:0] raw,
                            input logic signed [RAY_W-1:0] rx,
                            input logic signed [RAY_W-1:0] ry);
    int     gap;
    point_t p;
    gap = 0;
    // bursts of random length, with gaps between some of them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_stream && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid     <= 1'b1;
    pix_if.depth_raw <= raw;
    pix_if.ray_x     <= rx;
    pix_if.ray_y     <= ry;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    if (project_pixel(pose_cfg, raw, rx, ry, p)) begin
      expected_points.insert(expected_points.size(), p);
    end
  endtask

  task automatic pause_sender();
    @(negedge clk);
    pix_if.valid <= 1'b0;
  endtask

  // let every predicted point out, then let rejected pixels clear the stages
  task automatic wait_drained();
    pause_sender();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic signed [RAY_W-1:0] random_ray();
    case ($urandom_range(0, 9))
      0, 1:    return RAY_W'($urandom);
      2, 3, 4: return RAY_W'($urandom_range(0, 196608)) - 20'sd98304;
      default: return RAY_W'($urandom_range(0, 32768)) - 20'sd16384;
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [RAW_PORT_W-1:0] raw;
    logic [63:0]           target;
    int                    pick;
    pick = $urandom_range(0, 9);
    raw  = RAW_PORT_W'($urandom);
    // mostly aim the raw value into the depth window
    if (pick < 6 && pose_cfg.depth_scale != 0 &&
        pose_cfg.far_limit > pose_cfg.near_limit) begin
      target = 64'(pose_cfg.near_limit) +
               64'($urandom_range(0, pose_cfg.far_limit - pose_cfg.near_limit));
      target = (target << 16) / 64'(pose_cfg.depth_scale);
      if (target <= 64'hFFFF) raw = target[RAW_PORT_W-1:0];
    end else if (pick == 9) begin
      raw = RAW_PORT_W'($urandom_range(0, 255));
    end
    send_pixel(raw, random_ray(), random_ray());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers at reset give a zero far limit, so nothing comes out
  task automatic test_reset_rejects();
    send_pixel(16'hFFFF, RAY_MAX, RAY_MAX);
    send_pixel(16'h0000, RAY_MIN, RAY_MIN);
    send_pixel(16'd1234, 0, 0);
    wait_drained();
  endtask

  // depth exactly on near or far is dropped, one raw step inside is kept
  task automatic test_depth_window();
    cfg_t c;
    c = typical_pose();
    c.near_limit = NEAR_EDGE;
    load_pose(c);
    send_pixel(16'd0, 0, 0);
    send_pixel(16'hFFFF, 0, 0);
    send_pixel(16'd410, 0, 0);
    send_pixel(16'd411, 20'sd100, -20'sd100);
    send_pixel(16'd49152, 0, 0);
    send_pixel(16'd49151, -20'sd50, 20'sd50);
    wait_drained();
  endtask

  // a write to an index outside the map must leave the pose alone
  task automatic test_unused_index();
    cfg_write(REG_UNUSED, '1);
    send_pixel(16'd4096, 0, 0);
    send_pixel(16'd20000, 20'sd1000, -20'sd1000);
    wait_drained();
  endtask

  // at 1 m depth camera y equals the ray, so the height edge is exact
  task automatic test_height_gate();
    send_pixel(16'd4096, 0, RAY_HEIGHT);
    send_pixel(16'd4096, 0, RAY_HEIGHT - 20'sd1);
    send_pixel(16'd4096, 0, -RAY_HEIGHT);
    send_pixel(16'd4096, 0, -RAY_HEIGHT + 20'sd1);
    send_pixel(16'd4096, RAY_MAX, 0);
    send_pixel(16'd4096, RAY_MIN, 0);
    send_pixel(16'd4096, 0, RAY_MAX);
    wait_drained();
  endtask

  // near equal to far and near above far keep nothing
  task automatic test_limits_crossed();
    cfg_write(REG_DEPTH_LIMITS, with_junk(CFG_DATA_W'({FAR_TYP >> 1, FAR_TYP >> 1}),
                                          2 * LIM_W));
    send_pixel(16'd24577, 0, 0);
    wait_drained();
    cfg_write(REG_DEPTH_LIMITS, with_junk(CFG_DATA_W'({NEAR_EDGE, FAR_TYP}), 2 * LIM_W));
    send_pixel(16'd20000, 0, 0);
    send_pixel(16'd411, 0, 0);
    wait_drained();
  endtask

  // largest coefficients drive x and z into both saturation rails
  task automatic test_saturation();
    cfg_t c;
    c = typical_pose();
    c.rot_row_x    = pack_row(COEF_MAX, COEF_MAX, COEF_MAX);
    c.rot_row_y    = '0;
    c.rot_row_z    = pack_row(COEF_MAX, COEF_MAX, COEF_MAX);
    c.translation  = pack_trans(TRANS_MAX, 0, TRANS_MAX);
    c.near_limit   = '0;
    c.far_limit    = '1;
    c.height_limit = '1;
    load_pose(c);
    send_pixel(16'hFFFF, RAY_MAX, RAY_MAX);
    send_pixel(16'hFFFF, RAY_MIN, RAY_MIN);
    wait_drained();
    c.rot_row_x   = pack_row(COEF_MIN, COEF_MIN, COEF_MIN);
    c.rot_row_z   = pack_row(COEF_MIN, COEF_MIN, COEF_MIN);
    c.translation = pack_trans(TRANS_MIN, 0, TRANS_MIN);
    load_pose(c);
    send_pixel(16'hFFFF, RAY_MAX, RAY_MAX);
    send_pixel(16'hFFFF, RAY_MIN, RAY_MIN);
    wait_drained();
  endtask

  // random pixels under a run of pose settings
  task automatic test_random_poses();
    pose_kind_t kinds[7] = '{POSE_LEVEL, POSE_RANDOM, POSE_SWAPPED, POSE_FULL_SCALE,
                             POSE_RANDOM, POSE_FINE_SCALE, POSE_LEVEL};
    foreach (kinds[i]) begin
      load_pose(random_pose(kinds[i]));
      steady_stream = (i == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender until the pipeline has emptied
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_random_pixel();
      end
      wait_drained();
    end
    steady_stream = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // point receiver: stall pattern, renewed whenever pattern_age wraps to zero
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = 16'hFFFF;
        1:       stall_pattern = 16'($urandom) | 16'h0001;
        2:       stall_pattern = 16'h0001 << $urandom_range(0, 15);
        default: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
      endcase
    end
    pnt_if.ready <= stall_pattern[pattern_age % 16];
    pattern_age = (pattern_age + 1) % 64;
  end

  // ---------------------------------------------------------------------------
  // point checker
  // ---------------------------------------------------------------------------

  task automatic check_coord(input string axis, input logic signed [OUT_W-1:0] want,
                             input logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: world %s mismatch, expected %0d, got %0d", $time, axis, want, got);
    end
  endtask

  always @(posedge clk) begin : check_points
    point_t want;
    if (rst_n && pnt_if.valid && pnt_if.ready) begin
      if (expected_points.size() == 0) begin
        err_count++;
        $display("%0t: unexpected point word, expected none, got x=%0d y=%0d z=%0d",
                 $time, pnt_if.point_x, pnt_if.point_y, pnt_if.point_z);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        check_coord("x", want.x, pnt_if.point_x);
        check_coord("y", want.y, pnt_if.point_y);
        check_coord("z", want.z, pnt_if.point_z);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles without any handshake
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (pnt_if.valid && pnt_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d points outstanding",
               $time, IDLE_LIMIT, expected_points.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    pose_cfg         = '0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    pix_if.valid     = 1'b0;
    pix_if.depth_raw = '0;
    pix_if.ray_x     = '0;
    pix_if.ray_y     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_rejects();
    test_depth_window();
    test_unused_index();
    test_height_gate();
    test_limits_crossed();
    test_saturation();
    test_random_poses();

    // final drain and settle
    pause_sender();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (expected_points.size() != 0) begin
      err_count++;
      $display("%0t: %0d points never arrived", $time, expected_points.size());
    end

    $display("%0d depth pixels under %0d pose settings, %0d world points checked",
             pixels_sent, settings_used, points_checked);
    $display("covered window and height edges, crossed limits, saturation, unused index");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
